### design/bq_pkg.sv
`default_nettype none

package bq_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int DATA_W        = 32;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int ACC_W         = PROD_W + 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_A1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B0 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B2 = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
    } t_sample_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered;
        logic                     saturated;
    } t_result_beat;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [DATA_W-1:0]    value;
    } t_cfg_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A1,
        ST_MUL_A2,
        ST_ACC_W,
        ST_SAT_W,
        ST_MUL_B0,
        ST_MUL_B1,
        ST_MUL_B2,
        ST_ACC_Y,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB,
        ACC_ADD,
        ACC_CLEAR
    } t_acc_op;

    typedef enum logic [2:0] {
        SEL_A1_D1,
        SEL_A2_D2,
        SEL_B0_W,
        SEL_B1_D1,
        SEL_B2_D2
    } t_mul_sel;

    typedef struct packed {
        t_acc_op  acc_op;
        t_mul_sel mul_sel;
        logic     w_write;
        logic     y_write;
    } t_dp_cmd;

    typedef struct packed {
        logic out_full;
    } t_dp_sts;

endpackage

`default_nettype wire

### design/bq_chan_if.sv
`default_nettype none

interface bq_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/bq_ctrl.sv
`default_nettype none

module bq_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  bq_pkg::t_dp_sts  i_sts,
    output bq_pkg::t_dp_cmd  o_cmd
);
    import bq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL_A1;
                end
            end
            ST_MUL_A1: n_state = ST_MUL_A2;
            ST_MUL_A2: n_state = ST_ACC_W;
            ST_ACC_W:  n_state = ST_SAT_W;
            ST_SAT_W:  n_state = ST_MUL_B0;
            ST_MUL_B0: n_state = ST_MUL_B1;
            ST_MUL_B1: n_state = ST_MUL_B2;
            ST_MUL_B2: n_state = ST_ACC_Y;
            ST_ACC_Y:  n_state = ST_OUT;
            ST_OUT: begin
                if (!i_sts.out_full) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.acc_op  = ACC_HOLD;
        o_cmd.mul_sel = SEL_A1_D1;
        o_cmd.w_write = 1'b0;
        o_cmd.y_write = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc_op = ACC_LOAD;
                end
            end
            ST_MUL_A1: o_cmd.mul_sel = SEL_A1_D1;
            ST_MUL_A2: begin
                o_cmd.mul_sel = SEL_A2_D2;
                o_cmd.acc_op  = ACC_SUB;
            end
            ST_ACC_W:  o_cmd.acc_op = ACC_SUB;
            ST_SAT_W: begin
                o_cmd.w_write = 1'b1;
                o_cmd.acc_op  = ACC_CLEAR;
            end
            ST_MUL_B0: o_cmd.mul_sel = SEL_B0_W;
            ST_MUL_B1: begin
                o_cmd.mul_sel = SEL_B1_D1;
                o_cmd.acc_op  = ACC_ADD;
            end
            ST_MUL_B2: begin
                o_cmd.mul_sel = SEL_B2_D2;
                o_cmd.acc_op  = ACC_ADD;
            end
            ST_ACC_Y:  o_cmd.acc_op = ACC_ADD;
            ST_OUT:    o_cmd.y_write = !i_sts.out_full;
            default:   o_in_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

### design/bq_datapath.sv
`default_nettype none

module bq_datapath #(
    parameter int FRAC_BITS = bq_pkg::FRAC_BITS_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  bq_pkg::t_dp_cmd                          i_cmd,
    output bq_pkg::t_dp_sts                          o_sts,
    input  wire  signed [bq_pkg::SAMPLE_W-1:0]       i_sample,
    input  wire                                      i_cfg_valid,
    input  wire         [bq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire         [bq_pkg::DATA_W-1:0]         i_cfg_value,
    output logic                                     o_out_valid,
    input  wire                                      i_out_ready,
    output logic signed [bq_pkg::DATA_W-1:0]         o_filtered,
    output logic                                     o_saturated
);
    import bq_pkg::*;

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] UNITY   = DATA_W'(1) << FRAC_BITS;

    logic signed [DATA_W-1:0] r_a1;
    logic signed [DATA_W-1:0] r_a2;
    logic signed [DATA_W-1:0] r_b0;
    logic signed [DATA_W-1:0] r_b1;
    logic signed [DATA_W-1:0] r_b2;
    logic signed [DATA_W-1:0] r_d1;
    logic signed [DATA_W-1:0] r_d2;
    logic signed [DATA_W-1:0] r_w;
    logic                     r_clip;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_data;
    logic                     r_out_sat;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_sh;
    logic                     ovf_pos;
    logic                     ovf_neg;
    logic signed [DATA_W-1:0] sat_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= '0;
            r_a2 <= '0;
            r_b0 <= UNITY;
            r_b1 <= '0;
            r_b2 <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_A1:  r_a1 <= i_cfg_value;
                CFG_A2:  r_a2 <= i_cfg_value;
                CFG_B0:  r_b0 <= i_cfg_value;
                CFG_B1:  r_b1 <= i_cfg_value;
                CFG_B2:  r_b2 <= i_cfg_value;
                default: r_a1 <= r_a1;
            endcase
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            SEL_A1_D1: begin mul_a = r_a1; mul_b = r_d1; end
            SEL_A2_D2: begin mul_a = r_a2; mul_b = r_d2; end
            SEL_B0_W:  begin mul_a = r_b0; mul_b = r_w;  end
            SEL_B1_D1: begin mul_a = r_b1; mul_b = r_d1; end
            SEL_B2_D2: begin mul_a = r_b2; mul_b = r_d2; end
            default:   begin mul_a = r_a1; mul_b = r_d1; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        case (i_cmd.acc_op)
            ACC_LOAD:  n_acc = {{(ACC_W-SAMPLE_W){i_sample[SAMPLE_W-1]}}, i_sample} << FRAC_BITS;
            ACC_SUB:   n_acc = r_acc - prod_ext;
            ACC_ADD:   n_acc = r_acc + prod_ext;
            ACC_CLEAR: n_acc = '0;
            ACC_HOLD:  n_acc = r_acc;
            default:   n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign acc_sh  = r_acc >>> FRAC_BITS;
    assign ovf_pos = !acc_sh[ACC_W-1] && (|acc_sh[ACC_W-2:DATA_W-1]);
    assign ovf_neg = acc_sh[ACC_W-1] && !(&acc_sh[ACC_W-2:DATA_W-1]);

    always_comb begin
        if (ovf_pos) begin
            sat_val = SAT_MAX;
        end else if (ovf_neg) begin
            sat_val = SAT_MIN;
        end else begin
            sat_val = acc_sh[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.w_write) begin
            r_w    <= sat_val;
            r_clip <= ovf_pos || ovf_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_cmd.y_write) begin
            r_d2 <= r_d1;
            r_d1 <= r_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.y_write) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.y_write) begin
            r_out_data <= sat_val;
            r_out_sat  <= r_clip || ovf_pos || ovf_neg;
        end
    end

    assign o_sts.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_filtered     = r_out_data;
    assign o_saturated    = r_out_sat;

endmodule

`default_nettype wire

### design/biquad_iir_df2_fixed_core.sv
// Each sample is worked through five products on one shared 32x32 multiplier and
// the accumulate and saturate steps of the sequencer; a new sample is taken only
// once the sequencer has written its result and is back in idle.
// Next sample is taken while a result waits; the final step holds until it leaves.
// Reset (synchronous, active low) clears both delays, the result valid and the
// sequencer, and loads the coefficients with a1=a2=b1=b2=0 and b0=1.0.
`default_nettype none

module biquad_iir_df2_fixed_core #(
    parameter int FRAC_BITS = bq_pkg::FRAC_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bq_chan_if.sink    i_sample,
    bq_chan_if.sink    i_cfg,
    bq_chan_if.source  o_result
);
    import bq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    out_valid;
    logic    in_ready;

    assign i_cfg.ready    = 1'b1;
    assign i_sample.ready = in_ready;
    assign o_result.valid = out_valid;

    bq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bq_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sample    (i_sample.data.sample),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.data.index),
        .i_cfg_value (i_cfg.data.value),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_filtered  (o_result.data.filtered),
        .o_saturated (o_result.data.saturated)
    );

endmodule

`default_nettype wire

### design/bq_checker.sv
`default_nettype none

module bq_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                i_in_valid,
    input wire                                i_in_ready,
    input wire                                i_out_valid,
    input wire                                i_out_ready,
    input wire  [bq_pkg::DATA_W-1:0]          i_out_filtered,
    input wire                                i_out_saturated
);
    import bq_pkg::*;

    a_reset_clears_result: assert property (
        @(posedge i_clk) !i_rst_n |=> !i_out_valid
    ) else $error("result beat valid right after reset");

    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready
    ) else $error("sample taken while previous one still in work");

    a_stall_holds_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_filtered) && $stable(i_out_saturated))
    ) else $error("stalled result beat changed");

    a_result_drops_on_take: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(i_out_valid)) |-> $past(i_out_ready)
    ) else $error("result beat dropped without being taken");

endmodule

bind biquad_iir_df2_fixed_core bq_checker u_bq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_sample.valid),
    .i_in_ready      (i_sample.ready),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_out_filtered  (o_result.data.filtered),
    .i_out_saturated (o_result.data.saturated)
);

`default_nettype wire

### sim/biquad_iir_df2_fixed_core_tb.sv
`timescale 1ns / 100ps

module biquad_iir_df2_fixed_core_tb;
    import bq_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP = '1;
    localparam logic [DATA_W-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_MONE = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] Q_HALF = 32'h0000_8000;
    localparam logic signed [79:0] Y_MAX = 80'sd2147483647;
    localparam logic signed [79:0] Y_MIN = -80'sd2147483648;
    localparam int SAMPLE_TARGET  = 900;
    localparam int TAIL_ITEMS     = 120;
    localparam int SQUEEZE_AT     = 250;
    localparam int SQUEEZE_CYCLES = 90;

    typedef struct {
        bit                         is_cfg;
        t_cfg_beat                  cfg;
        logic signed [SAMPLE_W-1:0] sample;
    } t_feed_item;

    logic clk;
    logic rst_n;

    bq_chan_if #(.T(t_sample_beat)) sample_ch ();
    bq_chan_if #(.T(t_cfg_beat))    cfg_ch ();
    bq_chan_if #(.T(t_result_beat)) result_ch ();

    biquad_iir_df2_fixed_core dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_sample (sample_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    t_feed_item   feed_q[$];
    t_result_beat predicted_y[$];
    int           samples_queued;
    int           samples_sent;
    int           results_seen;
    int           mismatches;
    int           feed_gap;
    int           stall_left;
    int           squeezes;
    bit           calm_tail;

    logic signed [DATA_W-1:0] coef_a1, coef_a2, coef_b0, coef_b1, coef_b2;
    logic signed [DATA_W-1:0] delay_one, delay_two;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, what);
    endtask

    function automatic logic [DATA_W:0] clamp32(input logic signed [79:0] v);
        if (v > Y_MAX) return {1'b1, Q_MAX};
        if (v < Y_MIN) return {1'b1, Q_MIN};
        return {1'b0, v[DATA_W-1:0]};
    endfunction

    function automatic t_result_beat biquad_step(input logic signed [SAMPLE_W-1:0] x);
        logic signed [79:0] xs, a1, a2, b0, b1, b2, d1, d2, acc, ws;
        logic [DATA_W:0]    w_c, y_c;
        t_result_beat       r;
        xs = x;
        a1 = coef_a1;
        a2 = coef_a2;
        b0 = coef_b0;
        b1 = coef_b1;
        b2 = coef_b2;
        d1 = delay_one;
        d2 = delay_two;
        acc = (xs <<< FRAC) - a1 * d1 - a2 * d2;
        w_c = clamp32(acc >>> FRAC);
        ws = $signed(w_c[DATA_W-1:0]);
        acc = b0 * ws + b1 * d1 + b2 * d2;
        y_c = clamp32(acc >>> FRAC);
        delay_two = delay_one;
        delay_one = w_c[DATA_W-1:0];
        r.filtered  = y_c[DATA_W-1:0];
        r.saturated = w_c[DATA_W] | y_c[DATA_W];
        return r;
    endfunction

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
        t_feed_item it;
        it.is_cfg = 1'b0;
        it.cfg    = '0;
        it.sample = x;
        feed_q.push_back(it);
        samples_queued++;
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        t_feed_item it;
        it.is_cfg    = 1'b1;
        it.cfg.index = idx;
        it.cfg.value = val;
        it.sample    = '0;
        feed_q.push_back(it);
    endtask

    function automatic logic [DATA_W-1:0] pick_coeff(input int style, input int span);
        int v;
        case (style)
            0: v = int'($urandom_range(0, 2 * span)) - span;
            1: v = int'($urandom);
            default: begin
                case ($urandom_range(0, 6))
                    0: v = int'(Q_MIN);
                    1: v = int'(Q_MAX);
                    2: v = 0;
                    3: v = int'(Q_ONE);
                    4: v = int'(Q_MONE);
                    5: v = 1;
                    default: v = -1;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk) begin : feed_driver
        bit         s_hold, c_hold, nv_s, nv_c;
        t_feed_item head;
        if (!rst_n) begin
            sample_ch.valid <= 1'b0;
            cfg_ch.valid    <= 1'b0;
            feed_gap = 0;
        end else begin
            if (sample_ch.valid && sample_ch.ready) samples_sent++;
            s_hold = sample_ch.valid && !sample_ch.ready;
            c_hold = cfg_ch.valid && !cfg_ch.ready;
            if (feed_q.size() < TAIL_ITEMS) calm_tail <= 1'b1;
            if (!s_hold && !c_hold) begin
                nv_s = 1'b0;
                nv_c = 1'b0;
                if (feed_gap > 0) begin
                    feed_gap--;
                end else if (feed_q.size() != 0) begin
                    if (!calm_tail && (samples_sent / 64) % 4 != 3 &&
                        $urandom_range(0, 5) == 0) begin
                        feed_gap = $urandom_range(0, 12);
                    end else if (!feed_q[0].is_cfg) begin
                        head = feed_q.pop_front();
                        nv_s = 1'b1;
                        sample_ch.data.sample <= head.sample;
                    end else if (samples_sent == results_seen) begin
                        // hold config beats until every result has drained
                        head = feed_q.pop_front();
                        nv_c = 1'b1;
                        cfg_ch.data <= head.cfg;
                    end
                end
                sample_ch.valid <= nv_s;
                cfg_ch.valid    <= nv_c;
            end
        end
    end

    always @(posedge clk) begin : result_sink
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            result_ch.ready <= 1'b0;
        end else if (squeezes < 2 && results_seen >= SQUEEZE_AT * (squeezes + 1)) begin
            squeezes++;
            stall_left = SQUEEZE_CYCLES - 1;
            result_ch.ready <= 1'b0;
        end else if (!calm_tail && (results_seen / 64) % 4 != 1 &&
                     $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 12);
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : result_monitor
        t_result_beat got, want;
        if (!rst_n) begin
            coef_a1   = '0;
            coef_a2   = '0;
            coef_b0   = Q_ONE;
            coef_b1   = '0;
            coef_b2   = '0;
            delay_one = '0;
            delay_two = '0;
            predicted_y.delete();
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen <= results_seen + 1;
                got = result_ch.data;
                if (predicted_y.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result beat filtered=%0d",
                                            got.filtered));
                end else begin
                    want = predicted_y.pop_front();
                    if (got.filtered !== want.filtered)
                        flag_mismatch($sformatf("filtered got %0d want %0d",
                                                got.filtered, want.filtered));
                    if (got.saturated !== want.saturated)
                        flag_mismatch($sformatf("saturated got %0b want %0b (filtered %0d)",
                                                got.saturated, want.saturated,
                                                want.filtered));
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.data.index)
                    CFG_A1: coef_a1 = cfg_ch.data.value;
                    CFG_A2: coef_a2 = cfg_ch.data.value;
                    CFG_B0: coef_b0 = cfg_ch.data.value;
                    CFG_B1: coef_b1 = cfg_ch.data.value;
                    CFG_B2: coef_b2 = cfg_ch.data.value;
                    default: ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready)
                predicted_y.push_back(biquad_step(sample_ch.data.sample));
        end
    end

    initial begin : stimulus
        int style, len;
        rst_n = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        result_ch.ready = 1'b0;

        // pass-through with reset coefficients
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sh0000);
        push_sample(16'sh0001);
        push_sample(16'shFFFF);

        // writes to unused indexes must leave the filter alone
        push_cfg(CFG_IDX_W'(CFG_B2 + 1), 32'hFFFF_FFFF);
        push_cfg(CFG_IDX_W'(CFG_B2 + 2), 32'h0000_0000);
        push_cfg(CFG_TOP, $urandom);
        push_sample(16'sd12345);

        // extreme coefficients drive w and y into saturation
        push_cfg(CFG_A1, Q_MIN);
        push_cfg(CFG_A2, Q_MAX);
        push_cfg(CFG_B0, Q_MAX);
        push_cfg(CFG_B1, Q_MIN);
        push_cfg(CFG_B2, Q_MAX);
        repeat (3) push_sample(16'sh7FFF);
        repeat (3) push_sample(16'sh8000);

        // floor rounding of negative values
        push_cfg(CFG_A1, '0);
        push_cfg(CFG_A2, '0);
        push_cfg(CFG_B0, Q_HALF);
        push_cfg(CFG_B1, '0);
        push_cfg(CFG_B2, '0);
        push_sample(-16'sd1);
        push_sample(16'sd1);
        push_sample(-16'sd3);

        // delay taps only
        push_cfg(CFG_B0, '0);
        push_cfg(CFG_B1, Q_ONE);
        push_cfg(CFG_B2, Q_MONE);
        push_sample(16'sd100);
        push_sample(-16'sd200);
        push_sample(16'sd300);

        while (samples_queued < SAMPLE_TARGET) begin
            style = $urandom_range(0, 3);
            if (style == 3) begin
                push_cfg(CFG_IDX_W'($urandom_range(CFG_A1, CFG_B2)),
                         pick_coeff($urandom_range(0, 2), 65536));
                push_cfg(CFG_IDX_W'($urandom_range(CFG_B2 + 1, CFG_TOP)), $urandom);
            end else begin
                push_cfg(CFG_A1, pick_coeff(style, 120000));
                push_cfg(CFG_A2, pick_coeff(style, 60000));
                push_cfg(CFG_B0, pick_coeff(style, 131072));
                push_cfg(CFG_B1, pick_coeff(style, 131072));
                push_cfg(CFG_B2, pick_coeff(style, 131072));
            end
            len = $urandom_range(20, 90);
            repeat (len) begin
                if (style == 0 && $urandom_range(0, 1) == 0)
                    push_sample(16'(int'($urandom_range(0, 510)) - 255));
                else
                    push_sample(16'($urandom_range(0, 16'hFFFF)));
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (feed_q.size() != 0 || sample_ch.valid || cfg_ch.valid ||
               samples_sent != results_seen)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (predicted_y.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", predicted_y.size()));

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
design/bq_pkg.sv
design/bq_chan_if.sv
design/bq_ctrl.sv
design/bq_datapath.sv
design/biquad_iir_df2_fixed_core.sv
design/bq_checker.sv
sim/biquad_iir_df2_fixed_core_tb.sv
